### sv/mbs_pkg.sv
// Shared constants and types for the message block segmenter.
`timescale 1ns / 1ps

package mbs_pkg;

  // Default frame length in bytes, header included.
  localparam int unsigned BLOCK_BYTES_DEF = 64;
  // Header: index byte, then length high and low byte.
  localparam int unsigned HDR_BYTES       = 3;
  localparam int unsigned HDR_IDX         = 0;
  localparam int unsigned HDR_LEN_HI      = 1;
  localparam int unsigned HDR_LEN_LO      = 2;
  localparam logic [7:0]  FINAL_MARK      = 8'hFF;

  // Payload length width; covers the largest payload of a default-size frame (61 bytes).
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned LEN_FIELD_W     = 16;

  // One finished payload, handed from the front to the back.
  typedef struct packed {
    logic             final_blk;
    logic [7:0]       blk_idx;
    logic [LEN_W-1:0] len;
    logic             bank;
  } desc_t;

endpackage

### sv/mbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mbs_front.sv
// Front end: takes message bytes, fills the current payload bank, closes blocks.
`timescale 1ns / 1ps

module mbs_front import mbs_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int unsigned AW          = $clog2(2 * (BLOCK_BYTES - HDR_BYTES))
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  input  logic          q_full_i,
  output logic          push_o,
  output desc_t         desc_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o
);

  localparam int unsigned CAP = BLOCK_BYTES - HDR_BYTES;

  logic [LEN_W-1:0] fill_q, fill_d, fill_nxt;
  logic [7:0]       idx_q, idx_d;
  logic             bank_q, bank_d;
  logic             accept, done;

  // A free bank exists whenever the queue has room: queued entries own banks.
  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && !q_full_i;
  assign fill_nxt   = fill_q + LEN_W'(1);
  assign done       = last_i || (fill_nxt == LEN_W'(CAP));

  assign we_o    = accept;
  assign wdata_o = data_i;
  assign waddr_o = bank_q ? (AW'(CAP) + AW'(fill_q)) : AW'(fill_q);

  assign push_o           = accept && done;
  assign desc_o.final_blk = last_i;
  assign desc_o.blk_idx   = idx_q;
  assign desc_o.len       = fill_nxt;
  assign desc_o.bank      = bank_q;

  always_comb begin
    fill_d = fill_q;
    idx_d  = idx_q;
    bank_d = bank_q;
    if (accept) begin
      if (done) begin
        fill_d = '0;
        bank_d = !bank_q;
        idx_d  = last_i ? 8'd0 : idx_q + 8'd1;
      end else begin
        fill_d = fill_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      bank_q <= bank_d;
    end
  end

endmodule

### sv/mbs_queue.sv
// Two-entry descriptor queue between front and back.
`timescale 1ns / 1ps

module mbs_queue import mbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output desc_t head_o
);

  desc_t       ent_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

### sv/mbs_back.sv
// Back end: walks one frame per descriptor, header then payload then padding.
`timescale 1ns / 1ps

module mbs_back import mbs_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int unsigned AW          = $clog2(2 * (BLOCK_BYTES - HDR_BYTES))
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  desc_t         desc_i,
  output logic          pop_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [7:0]    rdata_i,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    m_tdata_o,
  output logic          m_tlast_o,
  output logic          m_tuser_o
);

  localparam int unsigned CAP = BLOCK_BYTES - HDR_BYTES;
  localparam int unsigned KW  = $clog2(BLOCK_BYTES);
  localparam int unsigned CW  = LEN_W + 1;

  logic [KW-1:0]          k_q, k_d;
  logic [CW-1:0]          k_ext, len_ext;
  logic [LEN_FIELD_W-1:0] len16;
  logic [AW-1:0]          pidx;
  logic                   advance, issue, k_last, use_ram;
  logic [7:0]             hdr_byte;

  logic                   ovalid_q;
  logic                   use_ram_q;
  logic [7:0]             hdr_q;
  logic                   tlast_q, tuser_q;

  assign advance = !ovalid_q || m_tready_i;
  assign issue   = q_valid_i && advance;
  assign k_last  = (k_q == KW'(BLOCK_BYTES - 1));
  assign pop_o   = issue && k_last;
  assign k_d     = issue ? (k_last ? '0 : k_q + KW'(1)) : k_q;

  assign k_ext   = CW'(k_q);
  assign len_ext = CW'(desc_i.len);
  assign len16   = LEN_FIELD_W'(desc_i.len);
  assign use_ram = (k_ext >= CW'(HDR_BYTES)) && (k_ext < len_ext + CW'(HDR_BYTES));

  assign pidx    = AW'(k_ext - CW'(HDR_BYTES));
  assign raddr_o = desc_i.bank ? (AW'(CAP) + pidx) : pidx;
  assign re_o    = issue && use_ram;

  always_comb begin
    hdr_byte = 8'd0;
    if (k_q == KW'(HDR_IDX)) begin
      hdr_byte = desc_i.final_blk ? FINAL_MARK : desc_i.blk_idx;
    end else if (k_q == KW'(HDR_LEN_HI)) begin
      hdr_byte = len16[15:8];
    end else if (k_q == KW'(HDR_LEN_LO)) begin
      hdr_byte = len16[7:0];
    end
  end

  // Output register; RAM read data holds while stalled since re stays low.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      use_ram_q <= use_ram;
      hdr_q     <= hdr_byte;
      tlast_q   <= k_last;
      tuser_q   <= k_last && desc_i.final_blk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (advance) begin
        ovalid_q <= q_valid_i;
      end
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = use_ram_q ? rdata_i : hdr_q;
  assign m_tlast_o  = tlast_q;
  assign m_tuser_o  = tuser_q;

endmodule

### sv/message_block_segmenter_unit.sv
// Top level of the message block segmenter: front, descriptor queue, payload RAM, back.
// Input: one byte per cycle while a payload bank is free; two banks of BLOCK_BYTES-3 bytes.
// Output: one frame byte per cycle while a descriptor is queued and tready is high; BLOCK_BYTES bytes per frame.
// Sustained: the front fills one payload bank while the back end sends the frame of the other.
// With the back end idle, the transfer closing a block is registered in the queue count, then in the output valid.
// Reset clears counters, queue and output valid; payload RAM is not cleared.
`timescale 1ns / 1ps

module message_block_segmenter_unit import mbs_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // end_of_block
  output logic       m_axis_tuser_o    // [0] end_of_message
);

  localparam int unsigned CAP   = BLOCK_BYTES - HDR_BYTES;
  localparam int unsigned DEPTH = 2 * CAP;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic          push, q_full, q_valid, pop;
  desc_t         push_desc, head_desc;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  mbs_front #(.BLOCK_BYTES(BLOCK_BYTES), .AW(AW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .data_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .desc_o     (push_desc),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata)
  );

  mbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .head_o  (head_desc)
  );

  mbs_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mbs_back #(.BLOCK_BYTES(BLOCK_BYTES), .AW(AW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .desc_i     (head_desc),
    .pop_o      (pop),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

### sv/mbs_checker.sv
// Port-level checker for the message block segmenter, bound to the top level.
`timescale 1ns / 1ps

module mbs_checker import mbs_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  localparam int unsigned KW = $clog2(BLOCK_BYTES);

  logic [KW-1:0] pos_q;
  logic          xfer;

  assign xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Byte position within the current output frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (xfer) begin
      pos_q <= m_axis_tlast_o ? '0 : pos_q + KW'(1);
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("output payload changed while stalled");

  a_eom_on_eob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("end of message without end of block");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (pos_q == KW'(BLOCK_BYTES - 1))))
    else $error("frame length differs from BLOCK_BYTES");

endmodule

bind message_block_segmenter_unit mbs_checker #(.BLOCK_BYTES(BLOCK_BYTES)) u_mbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
